// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ----- rtl/core/kpl_pkg.sv -----
package kpl_pkg;

    localparam logic [4:0] KEY_DIGIT_MAX = 5'd9;
    localparam logic [4:0] KEY_BACK      = 5'd12;
    localparam logic [4:0] KEY_CHANGE    = 5'd13;
    localparam logic [4:0] KEY_ENTER     = 5'd15;
    localparam logic [4:0] KEY_NONE      = 5'd16;

    localparam logic [4:0] POISON_DIGIT  = 5'd16;

    localparam logic [2:0] MODE_CHECK    = 3'b001;
    localparam logic [2:0] MODE_CHANGE   = 3'b010;
    localparam logic [2:0] MODE_POISON   = 3'b100;

    localparam int DISP_POS = 4;

    typedef enum logic [1:0] {
        SYM_DASH  = 2'd0,
        SYM_UNDER = 2'd1,
        SYM_MASK  = 2'd2
    } sym_t;

    typedef logic [4:0] entry_digit_t;
    typedef logic [3:0] pw_digit_t;

endpackage

// ----- rtl/core/keypad_password_lock.sv -----
// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+------------------------------------------
// input   | in        | in_valid/in_ready   | key_code
// output  | out       | out_valid/out_ready | digit_sym_0..3, unlock_pulse, alarm_pulse,
//         |           |                    | saved_flag, saved_digits
//
// Each accepted key code updates the lock state, and its result word appears in the
// output register on the next cycle, so one word is taken per cycle unless stalled.
// The output register is the only stage; in_ready drops only while a result waits
// and out_ready is low.
// Reset clears the whole lock state at once; no clearing pass is needed.
module keypad_password_lock
    import kpl_pkg::*;
#(
    parameter int PASSWORD_DIGITS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  key_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  digit_sym_0,
    output logic [1:0]  digit_sym_1,
    output logic [1:0]  digit_sym_2,
    output logic [1:0]  digit_sym_3,
    output logic        unlock_pulse,
    output logic        alarm_pulse,
    output logic        saved_flag,
    output logic [15:0] saved_digits
);

    localparam int CNT_W  = $clog2(PASSWORD_DIGITS + 2);
    localparam int SAVE_N = (PASSWORD_DIGITS < 4) ? PASSWORD_DIGITS : 4;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PASSWORD_DIGITS);
    localparam logic [CNT_W-1:0] CNT_EVAL = CNT_W'(PASSWORD_DIGITS + 1);

    logic                         held_reg,   held_next;
    logic [CNT_W-1:0]             cnt_reg,    cnt_next;
    entry_digit_t                 digits_reg  [PASSWORD_DIGITS];
    entry_digit_t                 digits_next [PASSWORD_DIGITS];
    sym_t                         disp_reg    [DISP_POS];
    sym_t                         disp_next   [DISP_POS];
    logic [2:0]                   mode_reg,   mode_next;
    logic                         fill_reg,   fill_next;
    pw_digit_t                    pw_reg      [PASSWORD_DIGITS];
    pw_digit_t                    pw_next     [PASSWORD_DIGITS];

    logic                         out_valid_reg;
    sym_t                         sym_out_reg [DISP_POS];
    logic                         unlock_reg;
    logic                         alarm_reg;
    logic                         saved_reg;
    logic [15:0]                  saved_digits_reg;

    logic                         unlock_now;
    logic                         alarm_now;
    logic                         saved_now;
    logic [15:0]                  saved_val;
    logic                         match;
    sym_t                         fill_sym;
    logic                         accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        held_next   = held_reg;
        cnt_next    = cnt_reg;
        digits_next = digits_reg;
        disp_next   = disp_reg;
        mode_next   = mode_reg;
        fill_next   = fill_reg;
        pw_next     = pw_reg;
        unlock_now  = 1'b0;
        alarm_now   = 1'b0;
        saved_now   = 1'b0;
        saved_val   = '0;
        match       = 1'b1;
        fill_sym    = fill_reg ? SYM_UNDER : SYM_DASH;

        if ((key_code < KEY_NONE) && !held_reg)
        begin
            held_next = 1'b1;
            if (key_code == KEY_BACK)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    for (int i = 0; i < PASSWORD_DIGITS - 1; i++)
                    begin
                        digits_next[i] = digits_reg[i + 1];
                    end
                    digits_next[PASSWORD_DIGITS - 1] = '0;
                    for (int i = 0; i < DISP_POS - 1; i++)
                    begin
                        disp_next[i] = disp_reg[i + 1];
                    end
                    disp_next[DISP_POS - 1] = fill_sym;
                end
            end
            else if (key_code <= KEY_DIGIT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
                for (int i = 1; i < PASSWORD_DIGITS; i++)
                begin
                    digits_next[i] = digits_reg[i - 1];
                end
                digits_next[0] = key_code;
                for (int i = 1; i < DISP_POS; i++)
                begin
                    disp_next[i] = disp_reg[i - 1];
                end
                disp_next[0] = SYM_MASK;
            end
            else if (cnt_reg < CNT_FULL)
            begin
                // A command before a full entry wipes the entry and alarms.
                cnt_next  = '0;
                alarm_now = 1'b1;
                for (int i = 0; i < PASSWORD_DIGITS; i++)
                begin
                    digits_next[i] = '0;
                end
                for (int i = 0; i < DISP_POS; i++)
                begin
                    disp_next[i] = fill_sym;
                end
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                if (key_code == KEY_CHANGE)
                begin
                    mode_next = mode_reg | MODE_CHANGE;
                end
                else if (key_code == KEY_ENTER)
                begin
                    mode_next = mode_reg | MODE_CHECK;
                end
                else
                begin
                    mode_next = mode_reg | MODE_POISON;
                    for (int i = 0; i < PASSWORD_DIGITS; i++)
                    begin
                        digits_next[i] = POISON_DIGIT;
                    end
                end
            end
        end
        else if (key_code >= KEY_NONE)
        begin
            held_next = 1'b0;
        end

        // The entry is judged once the key after a full entry is released.
        if ((cnt_next == CNT_EVAL) && !held_next)
        begin
            cnt_next = '0;
            for (int i = 0; i < PASSWORD_DIGITS; i++)
            begin
                if (digits_next[i] != {1'b0, pw_reg[i]})
                begin
                    match = 1'b0;
                end
            end
            if (mode_next == (MODE_CHECK | MODE_CHANGE))
            begin
                for (int i = 0; i < PASSWORD_DIGITS; i++)
                begin
                    pw_next[i] = digits_next[i][3:0];
                end
                for (int i = 0; i < SAVE_N; i++)
                begin
                    saved_val[4*i +: 4] = digits_next[i][3:0];
                end
                saved_now = 1'b1;
                mode_next = '0;
                fill_next = 1'b0;
            end
            else if ((mode_next == MODE_CHANGE) && match)
            begin
                fill_next = 1'b1;
            end
            else if ((mode_next == MODE_CHECK) && match)
            begin
                unlock_now = 1'b1;
                mode_next  = '0;
                fill_next  = 1'b0;
            end
            else
            begin
                alarm_now = 1'b1;
                mode_next = '0;
                fill_next = 1'b0;
            end
            for (int i = 0; i < DISP_POS; i++)
            begin
                disp_next[i] = fill_next ? SYM_UNDER : SYM_DASH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= '0;
            fill_reg <= 1'b0;
            for (int i = 0; i < PASSWORD_DIGITS; i++)
            begin
                digits_reg[i] <= '0;
                pw_reg[i]     <= '0;
            end
            for (int i = 0; i < DISP_POS; i++)
            begin
                disp_reg[i] <= SYM_DASH;
            end
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            fill_reg    <= fill_next;
            digits_reg  <= digits_next;
            pw_reg      <= pw_next;
            disp_reg    <= disp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_out_reg      <= disp_next;
            unlock_reg       <= unlock_now;
            alarm_reg        <= alarm_now;
            saved_reg        <= saved_now;
            saved_digits_reg <= saved_val;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_sym_0  = sym_out_reg[0];
    assign digit_sym_1  = sym_out_reg[1];
    assign digit_sym_2  = sym_out_reg[2];
    assign digit_sym_3  = sym_out_reg[3];
    assign unlock_pulse = unlock_reg;
    assign alarm_pulse  = alarm_reg;
    assign saved_flag   = saved_reg;
    assign saved_digits = saved_digits_reg;

endmodule

// ----- rtl/core/kpl_checker.sv -----
`include "assert_macros.svh"

module kpl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [4:0]  key_code,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  digit_sym_0,
    input logic [1:0]  digit_sym_1,
    input logic [1:0]  digit_sym_2,
    input logic [1:0]  digit_sym_3,
    input logic        unlock_pulse,
    input logic        alarm_pulse,
    input logic        saved_flag,
    input logic [15:0] saved_digits
);

    logic [26:0] out_word;

    assign out_word = {digit_sym_0, digit_sym_1, digit_sym_2, digit_sym_3,
                       unlock_pulse, alarm_pulse, saved_flag, saved_digits};

    // A stalled result word must hold still until it is taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

    // Every accepted key code shows its result word on the next cycle.
    `ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

    // A single word never both unlocks and alarms.
    `ASSERT_SAME(a_unlock_alarm_excl, clk, rst_n, out_valid, !(unlock_pulse && alarm_pulse))

    // The saved password is shown only in the word that stores it.
    `ASSERT_SAME(a_saved_zero, clk, rst_n, out_valid && !saved_flag, saved_digits == 16'd0)

endmodule

bind keypad_password_lock kpl_checker u_kpl_checker (.*);
